[sv/xoshiro256_random_generator_defines.svh]
// ============================================================================
// xoshiro256 random generator assertion macros
// Shared property shorthands for the generator's concurrent checks. Each
// macro samples on i_clk and is switched off while i_rst_n is low.
// ============================================================================
`ifndef XOSHIRO256_RANDOM_GENERATOR_DEFINES_SVH
`define XOSHIRO256_RANDOM_GENERATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define X256RG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define X256RG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/x256rg_pkg.sv]
// ============================================================================
// x256rg_pkg
// Types and constants for the xoshiro256** generator with splitmix64 seeding.
// ============================================================================
package x256rg_pkg;

    // Request command codes.
    localparam logic [1:0] CMD_RESEED = 2'd0;
    localparam logic [1:0] CMD_NEXT   = 2'd1;
    localparam logic [1:0] CMD_RANGE  = 2'd2;

    // splitmix64 constants and the all-zero state substitute.
    localparam logic [63:0] GOLDEN_INC   = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;
    localparam logic [63:0] NONZERO_FILL = 64'h0000000001234567;

    // xoshiro256** shift and rotate amounts.
    localparam int unsigned OUT_ROT     = 7;
    localparam int unsigned STATE_SHIFT = 17;
    localparam int unsigned STATE_ROT   = 45;

    // Sequencer limits.
    localparam logic [1:0] MUL_LAST  = 2'd2;
    localparam logic [1:0] WORD_LAST = 2'd3;
    localparam logic [5:0] DIV_LAST  = 6'd63;

    typedef struct packed {
        logic [1:0]         command;
        logic [63:0]        seed;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
    } t_in_req;

    typedef struct packed {
        logic [63:0]        raw_value;
        logic signed [31:0] ranged_value;
    } t_out_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_ADD,
        ST_MIX_MUL,
        ST_MIX_END,
        ST_DRAW,
        ST_SCALE,
        ST_DIV,
        ST_EMIT
    } t_state;

    function automatic logic [63:0] f_rotl7(input logic [63:0] v);
        return (v << OUT_ROT) | (v >> (64 - OUT_ROT));
    endfunction

    function automatic logic [63:0] f_rotl45(input logic [63:0] v);
        return (v << STATE_ROT) | (v >> (64 - STATE_ROT));
    endfunction

endpackage

[sv/xoshiro256_random_generator.sv]
// A raw next request passes through the draw, scale and emit states before its
// result appears; a non-empty range request adds the remainder loop, and an empty
// range request goes straight to emit. One request at a time: no new request is
// taken until the last is done. The bit-serial remainder loop takes one dividend
// bit per cycle and the one shared 32x32 multiplier takes three passes a product.
// Reset (synchronous, active low) starts a seed-zero expansion; requests stall.
// ============================================================================
// xoshiro256 random generator
// xoshiro256** generator with splitmix64 seeding and a bounded range mode,
// built around one shared multiplier and one serial remainder unit.
// ============================================================================
`include "xoshiro256_random_generator_defines.svh"

module xoshiro256_random_generator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  x256rg_pkg::t_in_req  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output x256rg_pkg::t_out_req o_out_data
);

    // ------------------------------------------------------------------------
    // Registers. The four generator words are read at fixed places during a
    // draw and written one at a time, indexed by the word counter, while
    // seeding, so they live in flip-flops.
    // ------------------------------------------------------------------------
    x256rg_pkg::t_state   r_state,     n_state;
    logic [63:0]          r_words [4];
    logic [63:0]          n_words [4];
    logic [1:0]           r_idx,       n_idx;
    logic [63:0]          r_acc,       n_acc;
    logic [63:0]          r_m,         n_m;
    logic [63:0]          r_prod,      n_prod;
    logic                 r_phase,     n_phase;
    logic [1:0]           r_step,      n_step;
    logic [63:0]          r_tmp,       n_tmp;
    logic [63:0]          r_raw,       n_raw;
    logic [63:0]          r_div,       n_div;
    logic [31:0]          r_rem,       n_rem;
    logic [32:0]          r_span,      n_span;
    logic [31:0]          r_lo,        n_lo;
    logic [5:0]           r_cnt,       n_cnt;
    logic                 r_is_range,  n_is_range;
    logic                 r_out_valid, n_out_valid;
    x256rg_pkg::t_out_req r_out,       n_out;

    // Combinational helpers.
    logic        in_acc;
    logic        out_free;
    logic        range_empty;
    logic [32:0] lo_ext;
    logic [32:0] hi_ext;
    logic [63:0] acc_sum;
    logic [63:0] mul_k;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] mix_out;
    logic [63:0] s1_x5;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] scaled;
    logic [32:0] rem_sh;
    logic [32:0] rem_diff;

    assign in_acc      = i_in_valid && (r_state == x256rg_pkg::ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != x256rg_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Span of a range request, exact in 33 bits: hi - lo + 1 reaches 2^32
    // for the full signed interval.
    assign lo_ext      = {i_in_data.range_low[31], i_in_data.range_low};
    assign hi_ext      = {i_in_data.range_high[31], i_in_data.range_high};
    assign range_empty = (i_in_data.range_high <= i_in_data.range_low);

    // splitmix64 running sum and the final mix of one output word.
    assign acc_sum = r_acc + x256rg_pkg::GOLDEN_INC;
    assign mix_out = r_prod ^ (r_prod >> 31);

    // Shared 32x32 multiplier. A 64-bit product modulo 2^64 takes three
    // passes: low x low, then low x high and high x low folded into the
    // upper half.
    assign mul_k = r_phase ? x256rg_pkg::MIX_MUL_B : x256rg_pkg::MIX_MUL_A;

    always_comb begin
        case (r_step)
            2'd0: begin
                mul_a = r_m[31:0];
                mul_b = mul_k[31:0];
            end
            2'd1: begin
                mul_a = r_m[31:0];
                mul_b = mul_k[63:32];
            end
            default: begin
                mul_a = r_m[63:32];
                mul_b = mul_k[31:0];
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // xoshiro256** scrambler and state transition. The multiplications by
    // five and nine are shift-and-add, split by the rotate between draw and scale.
    assign s1_x5  = r_words[1] + (r_words[1] << 2);
    assign t2     = r_words[2] ^ r_words[0];
    assign t3     = r_words[3] ^ r_words[1];
    assign scaled = r_tmp + (r_tmp << 3);

    // One restoring remainder step. The remainder stays below the span,
    // which is at most 2^32, so it fits 32 bits and the shifted value 33.
    assign rem_sh   = {r_rem, r_div[63]};
    assign rem_diff = rem_sh - r_span;

    // ------------------------------------------------------------------------
    // Sequencer: next state and datapath control.
    // ------------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_words     = r_words;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_m         = r_m;
        n_prod      = r_prod;
        n_phase     = r_phase;
        n_step      = r_step;
        n_tmp       = r_tmp;
        n_raw       = r_raw;
        n_div       = r_div;
        n_rem       = r_rem;
        n_span      = r_span;
        n_lo        = r_lo;
        n_cnt       = r_cnt;
        n_is_range  = r_is_range;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            x256rg_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.command)
                        x256rg_pkg::CMD_RESEED: begin
                            n_acc   = i_in_data.seed + x256rg_pkg::GOLDEN_INC;
                            n_idx   = '0;
                            n_state = x256rg_pkg::ST_MIX_ADD;
                        end
                        x256rg_pkg::CMD_NEXT: begin
                            n_is_range = 1'b0;
                            n_state    = x256rg_pkg::ST_DRAW;
                        end
                        x256rg_pkg::CMD_RANGE: begin
                            n_lo  = i_in_data.range_low;
                            n_rem = '0;
                            if (range_empty) begin
                                // Nothing drawn: result is the lower bound.
                                n_raw   = '0;
                                n_state = x256rg_pkg::ST_EMIT;
                            end else begin
                                n_span     = hi_ext - lo_ext + 33'd1;
                                n_is_range = 1'b1;
                                n_state    = x256rg_pkg::ST_DRAW;
                            end
                        end
                        default: begin
                            // The unused code is consumed without effect.
                            n_state = x256rg_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            x256rg_pkg::ST_MIX_ADD: begin
                n_acc   = acc_sum;
                n_m     = acc_sum ^ (acc_sum >> 30);
                n_phase = 1'b0;
                n_step  = '0;
                n_state = x256rg_pkg::ST_MIX_MUL;
            end

            x256rg_pkg::ST_MIX_MUL: begin
                if (r_step == 2'd0) begin
                    n_prod = mul_p;
                end else begin
                    n_prod = {r_prod[63:32] + mul_p[31:0], r_prod[31:0]};
                end
                if (r_step == x256rg_pkg::MUL_LAST) begin
                    n_state = x256rg_pkg::ST_MIX_END;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end

            x256rg_pkg::ST_MIX_END: begin
                if (!r_phase) begin
                    n_m     = r_prod ^ (r_prod >> 27);
                    n_phase = 1'b1;
                    n_step  = '0;
                    n_state = x256rg_pkg::ST_MIX_MUL;
                end else begin
                    n_words[r_idx] = mix_out;
                    if (r_idx == x256rg_pkg::WORD_LAST) begin
                        // An all-zero state would never leave zero.
                        if ((r_words[0] | r_words[1] | r_words[2] | mix_out) == 64'd0) begin
                            n_words[0] = x256rg_pkg::NONZERO_FILL;
                        end
                        n_state = x256rg_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 2'd1;
                        n_state = x256rg_pkg::ST_MIX_ADD;
                    end
                end
            end

            x256rg_pkg::ST_DRAW: begin
                n_tmp      = x256rg_pkg::f_rotl7(s1_x5);
                n_words[0] = r_words[0] ^ t3;
                n_words[1] = r_words[1] ^ t2;
                n_words[2] = t2 ^ (r_words[1] << x256rg_pkg::STATE_SHIFT);
                n_words[3] = x256rg_pkg::f_rotl45(t3);
                n_state    = x256rg_pkg::ST_SCALE;
            end

            x256rg_pkg::ST_SCALE: begin
                n_raw = scaled;
                n_rem = '0;
                if (r_is_range) begin
                    n_div   = scaled;
                    n_cnt   = '0;
                    n_state = x256rg_pkg::ST_DIV;
                end else begin
                    n_lo    = '0;
                    n_state = x256rg_pkg::ST_EMIT;
                end
            end

            x256rg_pkg::ST_DIV: begin
                n_div = r_div << 1;
                if (rem_sh >= r_span) begin
                    n_rem = rem_diff[31:0];
                end else begin
                    n_rem = rem_sh[31:0];
                end
                if (r_cnt == x256rg_pkg::DIV_LAST) begin
                    n_state = x256rg_pkg::ST_EMIT;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end

            x256rg_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out.raw_value    = r_raw;
                    n_out.ranged_value = r_lo + r_rem;
                    n_out_valid        = 1'b1;
                    n_state            = x256rg_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = x256rg_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // State register. Reset loads the running sum for a seed of zero and
    // starts the expansion, so the generator comes up with its defined state.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= x256rg_pkg::ST_MIX_ADD;
            r_idx       <= '0;
            r_acc       <= x256rg_pkg::GOLDEN_INC;
            r_phase     <= 1'b0;
            r_step      <= '0;
            r_cnt       <= '0;
            r_is_range  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_acc       <= n_acc;
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_is_range  <= n_is_range;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_words <= n_words;
        r_m     <= n_m;
        r_prod  <= n_prod;
        r_tmp   <= n_tmp;
        r_raw   <= n_raw;
        r_div   <= n_div;
        r_rem   <= n_rem;
        r_span  <= n_span;
        r_lo    <= n_lo;
        r_out   <= n_out;
    end

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    // During the division, the partial remainder must stay below the span.
    `X256RG_ASSERT_SAME(a_rem_below_span, r_state == x256rg_pkg::ST_DIV, {1'b0, r_rem} < r_span, "remainder not below span")
    // Whenever the block is idle, the generator state is non-zero.
    `X256RG_ASSERT_SAME(a_state_nonzero, r_state == x256rg_pkg::ST_IDLE, (r_words[0] | r_words[1] | r_words[2] | r_words[3]) != 64'd0, "generator state all zero")
    // The remainder loop runs exactly the full dividend width.
    `X256RG_ASSERT_NEXT(a_div_length, r_state == x256rg_pkg::ST_DIV && r_cnt == x256rg_pkg::DIV_LAST, r_state == x256rg_pkg::ST_EMIT, "division did not finish after last bit")
    // A result leaving the sequencer must appear at the output.
    `X256RG_ASSERT_NEXT(a_emit_valid, r_state == x256rg_pkg::ST_EMIT && out_free, r_out_valid && r_state == x256rg_pkg::ST_IDLE, "emitted result not presented")

endmodule

[tb/sv/xoshiro256_random_generator_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// xoshiro256 random generator checker
// Watches the request and result channels of the generator, keeps its own copy of the
// 256-bit state and compares every result with the oldest prediction.
// ============================================================================
module xoshiro256_random_generator_checker
    import x256rg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_in_req  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_out_req i_out_data,
    output int       o_fail_count,
    output int       o_pending
);

    localparam int REPORT_LIMIT = 10;

    logic [63:0] gen_state [4];
    t_out_req    results_due [$];
    int          mismatch_count = 0;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned amt);
        return (v << amt) | (v >> (64 - amt));
    endfunction

    function automatic logic [63:0] mix64(input logic [63:0] z);
        logic [63:0] m;
        m = (z ^ (z >> 30)) * MIX_MUL_A;
        m = (m ^ (m >> 27)) * MIX_MUL_B;
        return m ^ (m >> 31);
    endfunction

    // Four splitmix64 steps; the running sum gains the increment before each.
    task automatic load_seed_state(input logic [63:0] seed);
        logic [63:0] acc;
        acc = seed + GOLDEN_INC;
        for (int i = 0; i < 4; i++) begin
            acc = acc + GOLDEN_INC;
            gen_state[i] = mix64(acc);
        end
        if ((gen_state[0] | gen_state[1] | gen_state[2] | gen_state[3]) == 64'd0)
            gen_state[0] = NONZERO_FILL;
    endtask

    function automatic logic [63:0] step_generator();
        logic [63:0] word;
        logic [63:0] scaled;
        logic [63:0] shifted;
        scaled = gen_state[1] * 64'd5;
        word = rotl64(scaled, OUT_ROT) * 64'd9;
        shifted = gen_state[1] << STATE_SHIFT;
        gen_state[2] ^= gen_state[0];
        gen_state[3] ^= gen_state[1];
        gen_state[1] ^= gen_state[2];
        gen_state[0] ^= gen_state[3];
        gen_state[2] ^= shifted;
        gen_state[3] = rotl64(gen_state[3], STATE_ROT);
        return word;
    endfunction

    // The span is exact in 33 bits, so a full signed interval gives 2^32.
    function automatic logic [31:0] fold_into_range(input logic [63:0] word,
                                                    input logic [31:0] lo,
                                                    input logic [31:0] hi);
        logic [32:0] span;
        logic [63:0] rem;
        span = {hi[31], hi} - {lo[31], lo} + 33'd1;
        rem = word % {31'd0, span};
        return lo + rem[31:0];
    endfunction

    task automatic predict_request(input t_in_req req);
        t_out_req res;
        logic [63:0] word;
        case (req.command)
            CMD_RESEED: load_seed_state(req.seed);
            CMD_NEXT: begin
                res.raw_value = step_generator();
                res.ranged_value = '0;
                results_due.insert(results_due.size(), res);
            end
            CMD_RANGE: begin
                if ($signed(req.range_high) <= $signed(req.range_low)) begin
                    // An empty interval returns its lower bound and draws nothing.
                    res.raw_value = '0;
                    res.ranged_value = req.range_low;
                end else begin
                    word = step_generator();
                    res.raw_value = word;
                    res.ranged_value = fold_into_range(word, req.range_low, req.range_high);
                end
                results_due.insert(results_due.size(), res);
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input t_out_req want, input t_out_req got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: mismatch, %s: raw_value expected %h got %h, ranged_value expected %0d got %0d",
                     $realtime, what, want.raw_value, got.raw_value,
                     $signed(want.ranged_value), $signed(got.ranged_value));
    endtask

    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            load_seed_state(64'd0);
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    note_mismatch("result with nothing due", '0, i_out_data);
                end else begin
                    want = results_due.pop_front();
                    if (want.raw_value !== i_out_data.raw_value
                        || want.ranged_value !== i_out_data.ranged_value)
                        note_mismatch("wrong result", want, i_out_data);
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_request(i_in_data);
        end
        o_fail_count <= mismatch_count;
        o_pending <= results_due.size();
    end

endmodule

[tb/sv/xoshiro256_random_generator_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// xoshiro256 random generator testbench
// Drives reseed, next and range requests into the generator with random idle
// cycles on both sides; a separate checker predicts and compares the results.
// ============================================================================
module xoshiro256_random_generator_tb;
    import x256rg_pkg::*;

    localparam int RANDOM_REQUESTS = 1300;
    localparam int IDLE_PERCENT    = 38;
    localparam int DRAIN_CYCLES    = 100;
    // Stretch of the random part, counted in requests, with no idling at all.
    localparam int STEADY_FIRST    = 400;
    localparam int STEADY_LAST     = 650;
    // Command code that the block ignores.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    t_in_req  in_data   = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_out_req out_data;
    logic     steady    = 1'b0;
    int       fail_count;
    int       pending;

    always #10 clk = ~clk;

    xoshiro256_random_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    xoshiro256_random_generator_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The result side stalls at random, except during the steady stretch.
    always @(posedge clk) begin
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Offers one request, with a random number of idle cycles in front of it,
    // and returns at the edge where it is accepted. Valid stays high into the
    // next request when no idle cycle follows, so it is never lowered and
    // raised in the same time step.
    task automatic send_request(input t_in_req req);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic t_in_req build_request(input logic [1:0]  command,
                                              input logic [63:0] seed,
                                              input logic [31:0] lo,
                                              input logic [31:0] hi);
        t_in_req req;
        req.command    = command;
        req.seed       = seed;
        req.range_low  = lo;
        req.range_high = hi;
        return req;
    endfunction

    // Range bounds of several kinds: anything at all, narrow intervals, nearly
    // the whole signed range, intervals near zero up to 2^20 wide, and empty
    // intervals where the upper bound does not exceed the lower one.
    task automatic pick_bounds(output logic [31:0] lo, output logic [31:0] hi);
        case ($urandom_range(0, 4))
            0: begin
                lo = $urandom;
                hi = $urandom;
            end
            1: begin
                lo = $urandom;
                hi = lo + $urandom_range(1, 20);
            end
            2: begin
                lo = 32'h8000_0000 + $urandom_range(0, 3);
                hi = 32'h7FFF_FFFF - $urandom_range(0, 3);
            end
            3: begin
                lo = $urandom;
                hi = lo - $urandom_range(0, 5);
            end
            default: begin
                lo = $urandom_range(0, 2000) - 1000;
                hi = lo + $urandom_range(0, 1 << 20);
            end
        endcase
    endtask

    initial begin
        logic [31:0] lo;
        logic [31:0] hi;
        logic [1:0]  command;
        int          pick;
        int          counted;

        // Reset is held low from time zero; the block then expands seed zero on
        // its own and stalls requests until that pass is done.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests. The first draws come from the seed-zero state
        // left by reset.
        send_request(build_request(CMD_NEXT, '0, '0, '0));
        send_request(build_request(CMD_NEXT, '1, '1, '1));
        // Full signed interval, where the span reaches 2^32.
        send_request(build_request(CMD_RANGE, '0, 32'h8000_0000, 32'h7FFF_FFFF));
        // Empty intervals: equal bounds and reversed extremes.
        send_request(build_request(CMD_RANGE, '0, 32'd5, 32'd5));
        send_request(build_request(CMD_RANGE, '0, 32'h7FFF_FFFF, 32'h8000_0000));
        // Two-value intervals at zero and at both ends of the signed range.
        send_request(build_request(CMD_RANGE, '0, 32'd0, 32'd1));
        send_request(build_request(CMD_RANGE, '0, 32'hFFFF_FFFF, 32'd0));
        send_request(build_request(CMD_RANGE, '0, 32'h7FFF_FFFE, 32'h7FFF_FFFF));
        send_request(build_request(CMD_RANGE, '0, 32'h8000_0000, 32'h8000_0001));
        send_request(build_request(CMD_RANGE, '0, -32'sd100, 32'sd100));
        // The unused command code must be ignored whatever the other fields hold.
        send_request(build_request(CMD_SPARE, '1, '1, '0));
        send_request(build_request(CMD_NEXT, '0, '0, '0));
        // Reseed with all ones, then with the seed that makes the first
        // splitmix64 word zero, then with zero, which must match reset.
        send_request(build_request(CMD_RESEED, '1, '0, '0));
        send_request(build_request(CMD_NEXT, '0, '0, '0));
        send_request(build_request(CMD_RANGE, '0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_request(build_request(CMD_RESEED, 64'd0 - (GOLDEN_INC << 1), '0, '0));
        send_request(build_request(CMD_NEXT, '0, '0, '0));
        send_request(build_request(CMD_RESEED, '0, '1, '1));
        send_request(build_request(CMD_NEXT, '0, '0, '0));
        send_request(build_request(CMD_RESEED, {$urandom, $urandom}, '0, '0));
        send_request(build_request(CMD_RANGE, '0, 32'hFFFF_FF00, 32'h0000_0100));

        // Random part. Every field carries random content whatever the
        // command, so each bit of the request sees both values. Requests
        // with the unused code are noise and are not counted.
        counted = 0;
        while (counted < RANDOM_REQUESTS) begin
            steady <= (counted >= STEADY_FIRST) && (counted < STEADY_LAST);
            pick = $urandom_range(0, 99);
            if (pick < 10)
                command = CMD_RESEED;
            else if (pick < 50)
                command = CMD_NEXT;
            else if (pick < 95)
                command = CMD_RANGE;
            else
                command = CMD_SPARE;
            pick_bounds(lo, hi);
            send_request(build_request(command, {$urandom, $urandom}, lo, hi));
            if (command != CMD_SPARE)
                counted++;
        end
        in_valid <= 1'b0;
        steady   <= 1'b0;

        // Wait until every predicted result has arrived, then leave room for
        // anything spurious that the block might still emit.
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this time.
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/x256rg_pkg.sv
sv/xoshiro256_random_generator.sv
tb/sv/xoshiro256_random_generator_checker.sv
tb/sv/xoshiro256_random_generator_tb.sv
